[src/pbq_pkg.sv]
// ----------------------------------------------------------------------------
// pbq_pkg
// Shared types and constants for the peaking biquad with dry/wet mix:
// control word layout of the microprogram and fixed datapath widths.
// ----------------------------------------------------------------------------
`default_nettype none

package pbq_pkg;

	localparam int SAMPLE_W  = 24;
	localparam int COEF_W    = 32;
	localparam int PROD_W    = SAMPLE_W + COEF_W;  // exact Q6.50 product
	localparam int ACC_W     = PROD_W + 2;         // headroom for five products
	localparam int FRAC_SHIFT = 27;
	localparam int NUM_COEFS = 7;
	localparam int CFG_IDX_W = 3;
	localparam int STEP_W    = 4;

	localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 24'sh7fffff;
	localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 24'sh800000;
	localparam logic signed [COEF_W-1:0]   WET_RESET  = 32'sd134217728;

	localparam logic OP_FILTER = 1'b0;
	localparam logic OP_CLEAR  = 1'b1;

	// register indexes double as coefficient selects
	typedef enum logic [CFG_IDX_W-1:0] {
		COEF_FF0 = 3'd0,
		COEF_FF1 = 3'd1,
		COEF_FF2 = 3'd2,
		COEF_FB1 = 3'd3,
		COEF_FB2 = 3'd4,
		COEF_DRY = 3'd5,
		COEF_WET = 3'd6
	} coef_sel_t;

	typedef enum logic [2:0] {
		SRC_X,
		SRC_X1,
		SRC_X2,
		SRC_Y1,
		SRC_Y2,
		SRC_Z
	} src_sel_t;

	typedef enum logic [1:0] {
		ACC_NOP,
		ACC_LOAD,
		ACC_ADD,
		ACC_SUB
	} acc_op_t;

	typedef enum logic {
		SEQ_NEXT,
		SEQ_WAIT_END  // hold while the result register is full, then end
	} seq_op_t;

	typedef struct packed {
		coef_sel_t coef;
		src_sel_t  src;
		acc_op_t   acc;
		logic      take_z;
		logic      emit;
		seq_op_t   seq;
	} ctrl_t;

	localparam logic [STEP_W-1:0] LAST_STEP = 4'd9;

endpackage

`default_nettype wire

[src/peaking_biquad_dry_wet.sv]
// A filter item runs the ten-step program, the last step waiting while the result
// register is full; new items wait for it to end, a clear item does not start it.
// Item rate is set by the single shared 32x24 multiplier walked by the microprogram.
// The result register lets the next item start while a result waits downstream.
// Reset (arst_n low, async): histories zero, gains zero except wet_gain = 1.0.
// ----------------------------------------------------------------------------
// peaking_biquad_dry_wet
// Multichannel direct-form-1 biquad with dry/wet mix, microcoded datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module peaking_biquad_dry_wet #(
	parameter int CHANNELS = 2
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	input  wire logic [31:0]                   s_tdata,   // [0] channel, [24:1] sample_in
	input  wire logic                          s_tuser,   // [0] opcode
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	output logic [31:0]                        m_tdata,   // [0] channel_out, [24:1] sample_out
	input  wire logic                          cfg_we,
	input  wire logic [pbq_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [pbq_pkg::COEF_W-1:0]    cfg_data
);

	localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int SW   = pbq_pkg::SAMPLE_W;

	logic signed [pbq_pkg::COEF_W-1:0] coef_q [pbq_pkg::NUM_COEFS];
	logic signed [SW-1:0] x1_q [CHANNELS];
	logic signed [SW-1:0] x2_q [CHANNELS];
	logic signed [SW-1:0] y1_q [CHANNELS];
	logic signed [SW-1:0] y2_q [CHANNELS];

	logic                        busy_q;
	logic [pbq_pkg::STEP_W-1:0]  step_q;
	logic                        ch_q;
	logic signed [SW-1:0]        x_q;
	logic signed [SW-1:0]        z_q;
	logic                        m_valid_q;
	logic                        out_ch_q;
	logic signed [SW-1:0]        out_sample_q;

	pbq_pkg::ctrl_t              ctrl;
	logic [CH_W-1:0]             ch_idx;
	logic                        in_xfer;
	logic                        in_ch;
	logic                        ch_ok;
	logic                        out_free;
	logic                        emit_fire;
	logic signed [SW-1:0]        operand;
	logic signed [SW-1:0]        rounded;

	assign in_ch     = s_tdata[0];
	assign ch_ok     = (32'(in_ch) < CHANNELS);
	assign s_tready  = !busy_q;
	assign in_xfer   = s_tvalid && s_tready;
	assign ch_idx    = CH_W'(ch_q);
	assign out_free  = !m_valid_q || m_tready;
	assign emit_fire = busy_q && ctrl.emit && out_free;

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {7'b0, out_sample_q, out_ch_q};

	pbq_ucode_rom u_rom (
		.step (step_q),
		.ctrl (ctrl)
	);

	always_comb begin
		case (ctrl.src)
			pbq_pkg::SRC_X:  operand = x_q;
			pbq_pkg::SRC_X1: operand = x1_q[ch_idx];
			pbq_pkg::SRC_X2: operand = x2_q[ch_idx];
			pbq_pkg::SRC_Y1: operand = y1_q[ch_idx];
			pbq_pkg::SRC_Y2: operand = y2_q[ch_idx];
			pbq_pkg::SRC_Z:  operand = z_q;
			default:         operand = x_q;
		endcase
	end

	pbq_datapath u_dp (
		.clk     (clk),
		.acc_op  (busy_q ? ctrl.acc : pbq_pkg::ACC_NOP),
		.coef    (coef_q[ctrl.coef]),
		.operand (operand),
		.rounded (rounded)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < pbq_pkg::NUM_COEFS; i++)
				coef_q[i] <= (i == int'(pbq_pkg::COEF_WET)) ? pbq_pkg::WET_RESET : '0;
		end else if (cfg_we && cfg_index <= pbq_pkg::COEF_WET) begin
			coef_q[cfg_index] <= cfg_data;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (in_xfer) begin
			if (s_tuser == pbq_pkg::OP_FILTER && ch_ok) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end
		end else if (busy_q) begin
			case (ctrl.seq)
				pbq_pkg::SEQ_NEXT: step_q <= step_q + 1'b1;
				default: begin
					if (out_free)
						busy_q <= 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			ch_q <= in_ch;
			x_q  <= s_tdata[SW:1];
		end
		if (busy_q && ctrl.take_z)
			z_q <= rounded;
	end

	// per-channel history
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < CHANNELS; c++) begin
				x1_q[c] <= '0;
				x2_q[c] <= '0;
				y1_q[c] <= '0;
				y2_q[c] <= '0;
			end
		end else if (in_xfer && s_tuser == pbq_pkg::OP_CLEAR) begin
			for (int c = 0; c < CHANNELS; c++) begin
				x1_q[c] <= '0;
				x2_q[c] <= '0;
				y1_q[c] <= '0;
				y2_q[c] <= '0;
			end
		end else if (busy_q && ctrl.take_z) begin
			x2_q[ch_idx] <= x1_q[ch_idx];
			x1_q[ch_idx] <= x_q;
			y2_q[ch_idx] <= y1_q[ch_idx];
			y1_q[ch_idx] <= rounded;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (emit_fire) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_fire) begin
			out_ch_q     <= ch_q;
			out_sample_q <= rounded;
		end
	end

	a_clear_no_work: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer && s_tuser == pbq_pkg::OP_CLEAR |=> !busy_q)
		else $error("clear transfer started the program");

	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> step_q <= pbq_pkg::LAST_STEP)
		else $error("step counter ran past the program");

	a_emit_valid: assert property (@(posedge clk) disable iff (!arst_n)
		emit_fire |=> m_tvalid && !busy_q)
		else $error("emit did not present a result or did not end the item");

endmodule

`default_nettype wire

[src/pbq_ucode_rom.sv]
// ----------------------------------------------------------------------------
// pbq_ucode_rom
// Microprogram store: one control word per step of a filter item.
// ----------------------------------------------------------------------------
`default_nettype none

module pbq_ucode_rom (
	input  wire logic [pbq_pkg::STEP_W-1:0] step,
	output pbq_pkg::ctrl_t                  ctrl
);

	// Multiply issues one step ahead of its accumulate.
	always_comb begin
		ctrl = '{coef: pbq_pkg::COEF_FF0, src: pbq_pkg::SRC_X, acc: pbq_pkg::ACC_NOP,
			take_z: 1'b0, emit: 1'b0, seq: pbq_pkg::SEQ_NEXT};
		case (step)
			4'd0: begin
				ctrl.coef = pbq_pkg::COEF_FF0;
				ctrl.src  = pbq_pkg::SRC_X;
			end
			4'd1: begin
				ctrl.coef = pbq_pkg::COEF_FF1;
				ctrl.src  = pbq_pkg::SRC_X1;
				ctrl.acc  = pbq_pkg::ACC_LOAD;
			end
			4'd2: begin
				ctrl.coef = pbq_pkg::COEF_FF2;
				ctrl.src  = pbq_pkg::SRC_X2;
				ctrl.acc  = pbq_pkg::ACC_ADD;
			end
			4'd3: begin
				ctrl.coef = pbq_pkg::COEF_FB1;
				ctrl.src  = pbq_pkg::SRC_Y1;
				ctrl.acc  = pbq_pkg::ACC_ADD;
			end
			4'd4: begin
				ctrl.coef = pbq_pkg::COEF_FB2;
				ctrl.src  = pbq_pkg::SRC_Y2;
				ctrl.acc  = pbq_pkg::ACC_SUB;
			end
			4'd5: begin
				ctrl.coef = pbq_pkg::COEF_DRY;
				ctrl.src  = pbq_pkg::SRC_X;
				ctrl.acc  = pbq_pkg::ACC_SUB;
			end
			4'd6: begin
				// z rounds from the old sum while dry*x loads
				ctrl.acc    = pbq_pkg::ACC_LOAD;
				ctrl.take_z = 1'b1;
			end
			4'd7: begin
				ctrl.coef = pbq_pkg::COEF_WET;
				ctrl.src  = pbq_pkg::SRC_Z;
			end
			4'd8: begin
				ctrl.acc = pbq_pkg::ACC_ADD;
			end
			4'd9: begin
				ctrl.emit = 1'b1;
				ctrl.seq  = pbq_pkg::SEQ_WAIT_END;
			end
			default: begin
				ctrl.seq = pbq_pkg::SEQ_WAIT_END;
			end
		endcase
	end

endmodule

`default_nettype wire

[src/pbq_datapath.sv]
// ----------------------------------------------------------------------------
// pbq_datapath
// Shared multiplier, accumulator and round/saturate to Q1.23.
// ----------------------------------------------------------------------------
`default_nettype none

module pbq_datapath (
	input  wire logic                                clk,
	input  wire pbq_pkg::acc_op_t                    acc_op,
	input  wire logic signed [pbq_pkg::COEF_W-1:0]   coef,
	input  wire logic signed [pbq_pkg::SAMPLE_W-1:0] operand,
	output logic signed [pbq_pkg::SAMPLE_W-1:0]      rounded
);

	localparam int RND_W = pbq_pkg::ACC_W + 1;
	localparam int Q_W   = RND_W - pbq_pkg::FRAC_SHIFT;

	logic signed [pbq_pkg::PROD_W-1:0] prod_q;
	logic signed [pbq_pkg::ACC_W-1:0]  acc_q;
	logic signed [pbq_pkg::ACC_W-1:0]  prod_ext;
	logic signed [RND_W-1:0]           rnd_sum;
	logic signed [Q_W-1:0]             quot;

	assign prod_ext = pbq_pkg::ACC_W'(prod_q);

	always_ff @(posedge clk) begin
		prod_q <= coef * operand;
		case (acc_op)
			pbq_pkg::ACC_LOAD: acc_q <= prod_ext;
			pbq_pkg::ACC_ADD:  acc_q <= acc_q + prod_ext;
			pbq_pkg::ACC_SUB:  acc_q <= acc_q - prod_ext;
			default:           acc_q <= acc_q;
		endcase
	end

	// round half up, floor shift, clamp
	always_comb begin
		rnd_sum = RND_W'(acc_q) + (RND_W'(1) <<< (pbq_pkg::FRAC_SHIFT - 1));
		quot    = Q_W'(rnd_sum >>> pbq_pkg::FRAC_SHIFT);
		if (quot > Q_W'(pbq_pkg::SAMPLE_MAX))
			rounded = pbq_pkg::SAMPLE_MAX;
		else if (quot < Q_W'(pbq_pkg::SAMPLE_MIN))
			rounded = pbq_pkg::SAMPLE_MIN;
		else
			rounded = pbq_pkg::SAMPLE_W'(quot);
	end

endmodule

`default_nettype wire

[bench/peaking_biquad_dry_wet_tb.sv]
// ----------------------------------------------------------------------------
// peaking_biquad_dry_wet_tb
// Self-checking bench for the two-channel peaking biquad with dry/wet mix.
// A queue-fed driver streams filter and clear items while a bit-exact
// predictor tracks each channel's history and the gain registers; the
// monitor compares every result transfer against the oldest prediction.
// Gains are reprogrammed between phases while the block is idle, covering
// reset values, a directed filter, a realistic peaking EQ, full-scale
// extremes, random full-range gains and small gains that stress rounding.
// ----------------------------------------------------------------------------
`default_nettype none

module peaking_biquad_dry_wet_tb;

	localparam int LATENCY     = 11;
	localparam int HOLD_CYCLES = 400;
	localparam int STALL_LIMIT = 4000;
	localparam int MAX_REPORTS = 10;
	localparam logic signed [pbq_pkg::COEF_W-1:0] Q_ONE = 32'sd134217728;

	typedef struct packed {
		logic                                opcode;
		logic                                channel;
		logic signed [pbq_pkg::SAMPLE_W-1:0] sample;
	} biquad_item_t;

	typedef struct packed {
		logic                                channel;
		logic signed [pbq_pkg::SAMPLE_W-1:0] sample;
	} mix_result_t;

	logic                          clk       = 1'b0;
	logic                          arst_n    = 1'b0;
	logic                          s_tvalid  = 1'b0;
	logic                          s_tready;
	logic [31:0]                   s_tdata   = '0;  // [0] channel, [24:1] sample_in
	logic                          s_tuser   = 1'b0;  // [0] opcode
	logic                          m_tvalid;
	logic                          m_tready  = 1'b0;
	logic [31:0]                   m_tdata;   // [0] channel_out, [24:1] sample_out
	logic                          cfg_we    = 1'b0;
	logic [pbq_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [pbq_pkg::COEF_W-1:0]    cfg_data  = '0;

	peaking_biquad_dry_wet #(.CHANNELS(2)) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// predictor copy of gains and per-channel delay lines
	logic signed [pbq_pkg::COEF_W-1:0]   gain [pbq_pkg::NUM_COEFS];
	logic signed [pbq_pkg::SAMPLE_W-1:0] hist_x1 [2];
	logic signed [pbq_pkg::SAMPLE_W-1:0] hist_x2 [2];
	logic signed [pbq_pkg::SAMPLE_W-1:0] hist_y1 [2];
	logic signed [pbq_pkg::SAMPLE_W-1:0] hist_y2 [2];

	biquad_item_t pending_items [$];
	mix_result_t  expected_mix [$];

	logic idle_on    = 1'b1;
	logic hold_req   = 1'b0;
	logic hold_taken = 1'b0;
	int   hold_cnt   = 0;
	int   src_gap    = 0;
	int   sink_gap   = 0;
	int   stall_cycles = 0;

	int filter_count   = 0;
	int clear_count    = 0;
	int results_seen   = 0;
	int mismatches     = 0;
	int gain_settings  = 1;

	biquad_item_t next_item;
	mix_result_t  want;
	logic         got_channel;
	logic signed [pbq_pkg::SAMPLE_W-1:0] got_sample;

	// round half up at bit 27, floor shift, clamp to Q1.23
	function automatic logic signed [pbq_pkg::SAMPLE_W-1:0] round_to_q23(input longint acc);
		longint q;
		q = (acc + 64'sd67108864) >>> pbq_pkg::FRAC_SHIFT;
		if (q > longint'(pbq_pkg::SAMPLE_MAX))
			return pbq_pkg::SAMPLE_MAX;
		if (q < longint'(pbq_pkg::SAMPLE_MIN))
			return pbq_pkg::SAMPLE_MIN;
		return q[pbq_pkg::SAMPLE_W-1:0];
	endfunction

	task automatic predict_item(input logic opcode, input logic ch,
		input logic signed [pbq_pkg::SAMPLE_W-1:0] x);
		longint acc;
		logic signed [pbq_pkg::SAMPLE_W-1:0] z;
		mix_result_t r;
		if (opcode == pbq_pkg::OP_CLEAR) begin
			for (int c = 0; c < 2; c++) begin
				hist_x1[c] = '0;
				hist_x2[c] = '0;
				hist_y1[c] = '0;
				hist_y2[c] = '0;
			end
			clear_count++;
		end else begin
			acc = longint'(gain[pbq_pkg::COEF_FF0]) * longint'(x)
				+ longint'(gain[pbq_pkg::COEF_FF1]) * longint'(hist_x1[ch])
				+ longint'(gain[pbq_pkg::COEF_FF2]) * longint'(hist_x2[ch])
				- longint'(gain[pbq_pkg::COEF_FB1]) * longint'(hist_y1[ch])
				- longint'(gain[pbq_pkg::COEF_FB2]) * longint'(hist_y2[ch]);
			z = round_to_q23(acc);
			// clamped z is what goes into the feedback history
			hist_x2[ch] = hist_x1[ch];
			hist_y2[ch] = hist_y1[ch];
			hist_x1[ch] = x;
			hist_y1[ch] = z;
			acc = longint'(gain[pbq_pkg::COEF_DRY]) * longint'(x)
				+ longint'(gain[pbq_pkg::COEF_WET]) * longint'(z);
			r.channel = ch;
			r.sample  = round_to_q23(acc);
			expected_mix.push_back(r);
			filter_count++;
		end
	endtask

	task automatic report_mismatch(input string msg);
		mismatches++;
		if (mismatches <= MAX_REPORTS)
			$display("[%0t] mismatch: %s", $realtime, msg);
	endtask

	// driver: one item per transfer, random gaps between items while idle_on is set
	always @(posedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			src_gap  <= 0;
		end else begin
			if (s_tvalid && s_tready)
				predict_item(s_tuser, s_tdata[0], s_tdata[24:1]);
			if (!s_tvalid || s_tready) begin
				if (src_gap != 0) begin
					s_tvalid <= 1'b0;
					src_gap  <= src_gap - 1;
				end else if (idle_on && $urandom_range(0, 7) == 0) begin
					s_tvalid <= 1'b0;
					src_gap  <= $urandom_range(0, 13);
				end else if (pending_items.size() != 0) begin
					next_item = pending_items.pop_front();
					s_tdata   <= {7'd0, next_item.sample, next_item.channel};
					s_tuser   <= next_item.opcode;
					s_tvalid  <= 1'b1;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// monitor: result checks plus downstream backpressure
	always @(posedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			sink_gap <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got_channel = m_tdata[0];
				got_sample  = m_tdata[24:1];
				results_seen++;
				if (expected_mix.size() == 0) begin
					report_mismatch($sformatf("unexpected result ch=%0d sample=%0d",
						got_channel, got_sample));
				end else begin
					want = expected_mix.pop_front();
					if (got_channel !== want.channel || got_sample !== want.sample)
						report_mismatch($sformatf(
							"ch exp %0d got %0d, sample exp %0d got %0d",
							want.channel, got_channel, want.sample, got_sample));
				end
			end
			if (hold_req && !hold_taken) begin
				m_tready   <= 1'b0;
				hold_cnt   <= HOLD_CYCLES;
				hold_taken <= 1'b1;
			end else if (hold_cnt != 0) begin
				m_tready <= 1'b0;
				hold_cnt <= hold_cnt - 1;
			end else if (sink_gap != 0) begin
				m_tready <= 1'b0;
				sink_gap <= sink_gap - 1;
			end else if (idle_on && $urandom_range(0, 7) == 0) begin
				m_tready <= 1'b0;
				sink_gap <= $urandom_range(0, 13);
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// watchdog on cycles with no transfer of any kind
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
			if (stall_cycles == STALL_LIMIT) begin
				$display("timeout: no transfer for %0d cycles", STALL_LIMIT);
				$display("** peaking_biquad_dry_wet: FAILED **");
				$finish;
			end
		end
	end

	function automatic logic signed [pbq_pkg::SAMPLE_W-1:0] rand_sample();
		logic [31:0] r;
		r = $urandom;
		case ($urandom_range(0, 5))
			0: return pbq_pkg::SAMPLE_MAX;
			1: return pbq_pkg::SAMPLE_MIN;
			2: return $signed(r[17:0]);
			default: return r[pbq_pkg::SAMPLE_W-1:0];
		endcase
	endfunction

	function automatic logic signed [pbq_pkg::COEF_W-1:0] small_gain();
		int v;
		v = int'($urandom_range(0, 32'h1000_0000)) - 32'h0800_0000;
		return v;
	endfunction

	task automatic queue_random(input int n);
		biquad_item_t it;
		for (int i = 0; i < n; i++) begin
			it.opcode  = ($urandom_range(0, 99) < 4) ? pbq_pkg::OP_CLEAR : pbq_pkg::OP_FILTER;
			it.channel = 1'($urandom_range(0, 1));
			it.sample  = rand_sample();
			pending_items.push_back(it);
		end
	endtask

	task automatic queue_item(input logic op, input logic ch,
		input logic signed [pbq_pkg::SAMPLE_W-1:0] s);
		biquad_item_t it;
		it.opcode  = op;
		it.channel = ch;
		it.sample  = s;
		pending_items.push_back(it);
	endtask

	task automatic wait_drained();
		do
			@(negedge clk);
		while (pending_items.size() != 0 || s_tvalid || expected_mix.size() != 0);
		// a trailing clear gives no result, so let the pipeline settle too
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	task automatic write_reg(input pbq_pkg::coef_sel_t idx,
		input logic [pbq_pkg::COEF_W-1:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		gain[idx] = val;
	endtask

	task automatic set_gains(input logic [pbq_pkg::COEF_W-1:0] ff0, ff1, ff2, fb1, fb2,
		dry, wet);
		wait_drained();
		write_reg(pbq_pkg::COEF_FF0, ff0);
		write_reg(pbq_pkg::COEF_FF1, ff1);
		write_reg(pbq_pkg::COEF_FF2, ff2);
		write_reg(pbq_pkg::COEF_FB1, fb1);
		write_reg(pbq_pkg::COEF_FB2, fb2);
		write_reg(pbq_pkg::COEF_DRY, dry);
		write_reg(pbq_pkg::COEF_WET, wet);
		@(posedge clk);
		cfg_we <= 1'b0;
		gain_settings++;
		@(negedge clk);
	endtask

	initial begin
		for (int i = 0; i < pbq_pkg::NUM_COEFS; i++)
			gain[i] = '0;
		gain[pbq_pkg::COEF_WET] = pbq_pkg::WET_RESET;
		for (int c = 0; c < 2; c++) begin
			hist_x1[c] = '0;
			hist_x2[c] = '0;
			hist_y1[c] = '0;
			hist_y2[c] = '0;
		end

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// gains straight out of reset
		queue_item(pbq_pkg::OP_FILTER, 1'b0, pbq_pkg::SAMPLE_MAX);
		queue_item(pbq_pkg::OP_FILTER, 1'b1, pbq_pkg::SAMPLE_MIN);
		queue_item(pbq_pkg::OP_FILTER, 1'b0, -24'sd1);
		queue_item(pbq_pkg::OP_CLEAR, 1'b1, 24'sh123456);

		// directed: every tap in use, z saturating both ways, clears mid-stream
		set_gains(Q_ONE, Q_ONE >>> 1, -(Q_ONE >>> 2), Q_ONE >>> 2, -(Q_ONE >>> 3),
			Q_ONE >>> 2, (Q_ONE >>> 2) * 3);
		queue_item(pbq_pkg::OP_FILTER, 1'b0, pbq_pkg::SAMPLE_MAX);
		queue_item(pbq_pkg::OP_FILTER, 1'b0, pbq_pkg::SAMPLE_MAX);
		queue_item(pbq_pkg::OP_FILTER, 1'b0, pbq_pkg::SAMPLE_MAX);
		queue_item(pbq_pkg::OP_FILTER, 1'b1, pbq_pkg::SAMPLE_MIN);
		queue_item(pbq_pkg::OP_FILTER, 1'b1, pbq_pkg::SAMPLE_MIN);
		queue_item(pbq_pkg::OP_FILTER, 1'b1, pbq_pkg::SAMPLE_MIN);
		queue_item(pbq_pkg::OP_FILTER, 1'b0, 24'sd0);
		queue_item(pbq_pkg::OP_FILTER, 1'b1, 24'sd1);
		queue_item(pbq_pkg::OP_FILTER, 1'b0, -24'sd1);
		queue_item(pbq_pkg::OP_FILTER, 1'b1, 24'sh555555);
		queue_item(pbq_pkg::OP_FILTER, 1'b0, 24'shaaaaaa);
		queue_item(pbq_pkg::OP_CLEAR, 1'b1, 24'sh7f00ff);
		queue_item(pbq_pkg::OP_FILTER, 1'b0, 24'sd1);
		queue_item(pbq_pkg::OP_FILTER, 1'b1, -24'sd1);
		queue_item(pbq_pkg::OP_FILTER, 1'b0, pbq_pkg::SAMPLE_MIN);
		queue_item(pbq_pkg::OP_FILTER, 1'b0, pbq_pkg::SAMPLE_MAX);
		queue_item(pbq_pkg::OP_FILTER, 1'b1, 24'sd0);
		queue_item(pbq_pkg::OP_CLEAR, 1'b0, pbq_pkg::SAMPLE_MAX);
		queue_item(pbq_pkg::OP_FILTER, 1'b1, pbq_pkg::SAMPLE_MAX);
		queue_item(pbq_pkg::OP_FILTER, 1'b1, pbq_pkg::SAMPLE_MIN);

		// realistic peaking section, half dry / half wet; long downstream stall
		set_gains(32'sd146163107, -32'sd234881024, 32'sd96636764,
			-32'sd234881024, 32'sd108716360, Q_ONE >>> 1, Q_ONE >>> 1);
		queue_random(160);
		hold_req = 1'b1;

		// full-scale gains of mixed sign
		set_gains(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
			32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
		queue_random(80);

		set_gains(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
			32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		queue_random(50);

		set_gains($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
		queue_random(110);

		// sub-unity gains keep the output off the rails, so rounding shows
		set_gains(small_gain(), small_gain(), small_gain(), small_gain(),
			small_gain(), small_gain(), small_gain());
		queue_random(130);

		// closing stretch at full rate on both sides
		set_gains(Q_ONE, -(Q_ONE >>> 1), Q_ONE >>> 3, -(Q_ONE >>> 1), Q_ONE >>> 2,
			-(Q_ONE >>> 2), Q_ONE);
		idle_on = 1'b0;
		queue_random(140);

		wait_drained();
		repeat (LATENCY * 2) @(posedge clk);

		$display("ran %0d filter items and %0d clears under %0d gain settings",
			filter_count, clear_count, gain_settings);
		$display("checked %0d results, %0d mismatches", results_seen, mismatches);
		if (mismatches == 0 && expected_mix.size() == 0)
			$display("** peaking_biquad_dry_wet: PASSED **");
		else
			$display("** peaking_biquad_dry_wet: FAILED **");
		$finish;
	end

endmodule

`default_nettype wire
